[src/exbus_pkg.sv]
package exbus_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_CHAN = 2'd1,
        EV_CRC  = 2'd2,
        EV_TELE = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        PS_IDLE    = 3'd0,
        PS_BUS     = 3'd1,
        PS_LEN     = 3'd2,
        PS_FILL    = 3'd3,
        PS_DISCARD = 3'd4,
        PS_LAST    = 3'd5
    } t_pstate;

    typedef enum logic [2:0] {
        BS_WAIT  = 3'd0,
        BS_RD    = 3'd1,
        BS_UNPK  = 3'd2,
        BS_OUT   = 3'd3,
        BS_FS    = 3'd4
    } t_bstate;

    typedef enum logic [1:0] {
        REG_IDLE_LIMIT     = 2'd0,
        REG_FAILSAFE_LIMIT = 2'd1,
        REG_TIMEOUT_VALUE  = 2'd2
    } t_reg;

    localparam logic [7:0] SYNC_A    = 8'h3b;
    localparam logic [7:0] SYNC_B    = 8'h3d;
    localparam logic [7:0] SYNC_C    = 8'h3e;
    localparam logic [7:0] BUS_REL   = 8'h01;
    localparam logic [7:0] ID_CHAN   = 8'h31;
    localparam logic [7:0] ID_TELE   = 8'h3a;
    localparam logic [7:0] SAT_MAX   = 8'hff;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [3:0] channel_index;
    } t_in;

    typedef struct packed {
        logic [15:0] channel_value;
        logic [1:0]  frame_event;
        logic [7:0]  request_id;
        logic        bus_released;
        logic [15:0] error_total;
        logic [15:0] good_total;
    } t_out;

    // Work handed from front to back.
    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] chan;
        logic       crc_ok;      // frame end, crc good
        logic       crc_bad;     // frame end, crc bad
        logic       failsafe;    // tick crossed failsafe limit
        logic       release_f;
    } t_job;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[src/exbus_frame_receiver_top.sv]
// Frame receiver for a sync-framed serial channel bus, CRC-16 checked.
// Flow: each byte, tick or read passes the front, the 2-entry queue and the
// back end, which goes from WAIT to OUT and registers the result; a tick that
// trips failsafe goes through FS, a good frame end reads the header (RD), and a
// channel frame then unpacks each channel (UNPK). The back end takes one word
// at a time; the front takes the next words into a 2-entry queue while it works.
// Reset: synchronous active-low i_rst_n clears parser, counters and channels.
module exbus_frame_receiver_top #(
    parameter int CHANNELS     = 16,
    parameter int BUFFER_BYTES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  exbus_pkg::t_in       i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output exbus_pkg::t_out      o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]  r_idle_limit, r_fs_limit;
    logic [15:0] r_timeout;

    // Configuration registers; always ready.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= 8'd5;
            r_fs_limit   <= 8'd75;
            r_timeout    <= 16'd65534;
        end else if (i_cfg_valid) begin
            case (exbus_pkg::t_reg'(i_cfg_index))
                exbus_pkg::REG_IDLE_LIMIT:     r_idle_limit <= i_cfg_data[7:0];
                exbus_pkg::REG_FAILSAFE_LIMIT: r_fs_limit   <= i_cfg_data[7:0];
                exbus_pkg::REG_TIMEOUT_VALUE:  r_timeout    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic            w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    exbus_pkg::t_job w_fj, w_bj;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    logic [7:0]      w_wr_data;

    // Front: parse bytes, run the CRC, store the frame, age counters.
    exbus_front #(.BUFFER_BYTES(BUFFER_BYTES), .AW(AW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_data,
        .i_idle_limit(r_idle_limit), .i_failsafe_limit(r_fs_limit),
        .o_job_valid(w_fj_valid), .i_job_ready(w_fj_ready), .o_job(w_fj),
        .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr), .o_wr_data(w_wr_data)
    );

    // Hold each word's work until the back end is free.
    exbus_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fj_valid), .o_ready(w_fj_ready), .i_job(w_fj),
        .o_valid(w_bj_valid), .i_ready(w_bj_ready), .o_job(w_bj)
    );

    // Back: unpack channels, apply failsafe, build the result word.
    exbus_back #(.CHANNELS(CHANNELS), .BUFFER_BYTES(BUFFER_BYTES), .AW(AW)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_bj_valid), .o_job_ready(w_bj_ready), .i_job(w_bj),
        .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr), .i_wr_data(w_wr_data),
        .i_timeout_value(r_timeout),
        .o_valid, .i_ready, .o_data
    );
endmodule

[src/exbus_front.sv]
module exbus_front #(
    parameter int BUFFER_BYTES = 128,
    parameter int AW = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  exbus_pkg::t_in        i_data,
    input  logic [7:0]            i_idle_limit,
    input  logic [7:0]            i_failsafe_limit,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output exbus_pkg::t_job       o_job,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [7:0]            o_wr_data
);
    exbus_pkg::t_pstate r_state, n_state;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic        r_rel, n_rel;
    logic [7:0]  r_idle, n_idle;
    logic [7:0]  r_fs, n_fs;
    logic [7:0]  r_first, n_first;   // copy of stored byte 0
    logic [7:0]  r_id4, n_id4;       // copy of stored byte 4
    logic [15:0] w_crc;
    logic        w_go;
    exbus_pkg::t_job w_job;

    assign o_ready = i_job_ready;
    assign w_go    = i_valid && i_job_ready;
    assign w_crc   = exbus_pkg::crc_step(r_crc, i_data.rx_byte);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_len   = r_len;
        n_crc   = r_crc;
        n_rel   = r_rel;
        n_idle  = r_idle;
        n_fs    = r_fs;
        n_first = r_first;
        n_id4   = r_id4;
        w_job   = '0;
        w_job.cmd  = exbus_pkg::t_cmd'(i_data.command);
        w_job.chan = i_data.channel_index;
        o_wr_en   = 1'b0;
        o_wr_addr = r_pos[AW-1:0];
        o_wr_data = i_data.rx_byte;
        if (w_go) begin
            unique case (exbus_pkg::t_cmd'(i_data.command))
                exbus_pkg::CMD_BYTE: begin
                    n_idle = '0;
                    if (r_state != exbus_pkg::PS_DISCARD) begin
                        o_wr_en = ({1'b0, r_pos} < 9'(BUFFER_BYTES));
                        if (r_pos == 8'd0) begin
                            n_first = i_data.rx_byte;
                        end
                        if (r_pos == 8'd4) begin
                            n_id4 = i_data.rx_byte;
                        end
                        n_pos = r_pos + 8'd1;
                    end
                    n_crc = w_crc;
                    unique case (r_state)
                        exbus_pkg::PS_IDLE: begin
                            if (i_data.rx_byte == exbus_pkg::SYNC_A
                                || i_data.rx_byte == exbus_pkg::SYNC_B
                                || i_data.rx_byte == exbus_pkg::SYNC_C) begin
                                n_state = exbus_pkg::PS_BUS;
                            end else begin
                                n_pos = '0;
                                n_crc = '0;
                            end
                        end
                        exbus_pkg::PS_BUS: begin
                            n_rel   = (i_data.rx_byte == exbus_pkg::BUS_REL);
                            n_state = exbus_pkg::PS_LEN;
                        end
                        exbus_pkg::PS_LEN: begin
                            n_len = i_data.rx_byte;
                            if ({1'b0, i_data.rx_byte} > 9'(BUFFER_BYTES)
                                || n_first == exbus_pkg::SYNC_A) begin
                                n_state = exbus_pkg::PS_DISCARD;
                            end else begin
                                n_state = exbus_pkg::PS_FILL;
                            end
                        end
                        exbus_pkg::PS_FILL: begin
                            if ({1'b0, n_pos} + 9'd1 >= {1'b0, r_len}) begin
                                n_state = exbus_pkg::PS_LAST;
                            end
                        end
                        exbus_pkg::PS_DISCARD: begin
                            n_pos = r_pos + 8'd1;
                            if (r_pos >= r_len) begin
                                n_state = exbus_pkg::PS_IDLE;
                                n_pos   = '0;
                                n_crc   = '0;
                            end
                        end
                        default: begin
                            w_job.crc_ok  = (w_crc == 16'd0);
                            w_job.crc_bad = (w_crc != 16'd0);
                            // A good channel frame restarts the failsafe count.
                            if (w_crc == 16'd0 && n_id4 == exbus_pkg::ID_CHAN) begin
                                n_fs = '0;
                            end
                            n_pos   = '0;
                            n_crc   = '0;
                            n_state = exbus_pkg::PS_IDLE;
                        end
                    endcase
                end
                exbus_pkg::CMD_TICK: begin
                    if (r_idle != exbus_pkg::SAT_MAX) begin
                        n_idle = r_idle + 8'd1;
                    end
                    if (n_idle >= i_idle_limit) begin
                        n_pos = '0;
                    end
                    if (r_fs != exbus_pkg::SAT_MAX) begin
                        n_fs = r_fs + 8'd1;
                    end
                    w_job.failsafe = (n_fs >= i_failsafe_limit);
                end
                default: begin
                end
            endcase
        end
        w_job.release_f = n_rel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= exbus_pkg::PS_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_rel   <= 1'b0;
            r_idle  <= '0;
            r_fs    <= '0;
            r_first <= '0;
            r_id4   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_rel   <= n_rel;
            r_idle  <= n_idle;
            r_fs    <= n_fs;
            r_first <= n_first;
            r_id4   <= n_id4;
        end
    end

    assign o_job_valid = w_go;
    assign o_job       = w_job;
endmodule

[src/exbus_queue.sv]
module exbus_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  exbus_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output exbus_pkg::t_job o_job
);
    exbus_pkg::t_job r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_job   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
        end
    end
endmodule

[src/exbus_back.sv]
module exbus_back #(
    parameter int CHANNELS     = 16,
    parameter int BUFFER_BYTES = 128,
    parameter int AW           = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  exbus_pkg::t_job i_job,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [7:0]      i_wr_data,
    input  logic [15:0]     i_timeout_value,
    output logic            o_valid,
    input  logic            i_ready,
    output exbus_pkg::t_out o_data
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = (CW > 4) ? CW : 4;

    logic [7:0]  r_mem [BUFFER_BYTES];
    logic [7:0]  r_rdata;
    logic [8:0]  r_raddr;

    logic [15:0] r_chan [CHANNELS];
    logic [15:0] r_bad, n_bad, r_ok, n_ok;
    exbus_pkg::t_bstate r_st, n_st;
    exbus_pkg::t_job    r_job;
    logic [2:0]  r_hdr, n_hdr;     // header byte step 3..5
    logic [7:0]  r_req, n_req;
    logic [7:0]  r_id, n_id;
    logic [6:0]  r_n, n_n;         // channels to load
    logic [6:0]  r_ci, n_ci;       // channel index
    logic        r_hi, n_hi;       // high byte phase
    logic [7:0]  r_lo, n_lo;
    logic [8:0]  w_addr;
    logic [7:0]  w_byte;
    logic        w_take;
    logic        w_ld;
    logic        w_fs_all;
    logic [XW-1:0] w_rch;
    exbus_pkg::t_out r_out, n_out;
    logic        r_ov, n_ov;

    // Memory with registered read; addresses past the buffer read zero.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[w_addr[AW-1:0]];
        r_raddr <= w_addr;
    end
    assign w_byte = ({1'b0, r_raddr} < 10'(BUFFER_BYTES)) ? r_rdata : 8'd0;

    assign o_job_ready = (r_st == exbus_pkg::BS_WAIT) && !r_ov;
    assign w_take      = i_job_valid && o_job_ready;

    always_comb begin
        n_st  = r_st;
        n_hdr = r_hdr;
        n_req = r_req;
        n_id  = r_id;
        n_n   = r_n;
        n_ci  = r_ci;
        n_hi  = r_hi;
        n_lo  = r_lo;
        n_bad = r_bad;
        n_ok  = r_ok;
        w_addr = 9'd3;
        unique case (r_st)
            exbus_pkg::BS_WAIT: begin
                if (w_take) begin
                    if (i_job.crc_ok) begin
                        n_st  = exbus_pkg::BS_RD;
                        n_hdr = 3'd3;
                        n_ok  = r_ok + 16'd1;
                    end else if (i_job.failsafe) begin
                        n_st = exbus_pkg::BS_FS;
                    end else begin
                        n_st = exbus_pkg::BS_OUT;
                        if (i_job.crc_bad) n_bad = r_bad + 16'd1;
                    end
                end
            end
            exbus_pkg::BS_RD: begin
                // r_hdr was presented last cycle; w_byte holds it now
                w_addr = {6'd0, r_hdr} + 9'd1;
                n_hdr  = r_hdr + 3'd1;
                if (r_hdr == 3'd3) n_req = w_byte;
                if (r_hdr == 3'd4) n_id  = w_byte;
                if (r_hdr == 3'd5) begin
                    n_n = ({1'b0, w_byte[7:1]} > 8'(CHANNELS)) ? 7'(CHANNELS)
                                                              : w_byte[7:1];
                    n_ci = '0;
                    n_hi = 1'b0;
                    w_addr = 9'd6;
                    n_st = (r_id == exbus_pkg::ID_CHAN) ? exbus_pkg::BS_UNPK
                                                         : exbus_pkg::BS_OUT;
                end
            end
            exbus_pkg::BS_UNPK: begin
                w_addr = 9'd7 + {1'b0, r_ci, 1'b0} + {8'd0, r_hi};
                if (r_ci == r_n) begin
                    n_st = exbus_pkg::BS_OUT;
                end else if (!r_hi) begin
                    n_lo = w_byte;
                    n_hi = 1'b1;
                end else begin
                    n_hi = 1'b0;
                    n_ci = r_ci + 7'd1;
                end
            end
            exbus_pkg::BS_FS: begin
                n_st = exbus_pkg::BS_OUT;
            end
            default: begin
                n_st = exbus_pkg::BS_WAIT;
            end
        endcase
    end

    // Pipeline the unpack: the byte is valid in the cycle after its address is issued.
    // Address in UNPK is one ahead, so first UNPK cycle uses byte 6 issued at end of RD.
    assign w_ld     = (r_st == exbus_pkg::BS_UNPK) && (r_ci != r_n) && r_hi;
    assign w_fs_all = (r_st == exbus_pkg::BS_FS);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CHANNELS; k++) begin
            if (!i_rst_n) begin
                r_chan[k] <= '0;
            end else if (w_fs_all) begin
                r_chan[k] <= i_timeout_value;
            end else if (w_ld && r_ci[CW-1:0] == CW'(k)) begin
                r_chan[k] <= {w_byte, r_lo};
            end
        end
    end

    assign w_rch = XW'(r_job.chan);

    always_comb begin
        n_out = r_out;
        n_ov  = r_ov;
        if (r_ov && i_ready) n_ov = 1'b0;
        if (n_st == exbus_pkg::BS_OUT && r_st != exbus_pkg::BS_OUT) begin
            n_out = '0;
        end
        if (r_st == exbus_pkg::BS_OUT) begin
            n_ov = 1'b1;
            n_out.bus_released = r_job.release_f;
            n_out.error_total  = r_bad;
            n_out.good_total   = r_ok;
            n_out.channel_value = '0;
            n_out.frame_event   = exbus_pkg::EV_NONE;
            n_out.request_id    = '0;
            if (r_job.cmd == exbus_pkg::CMD_READ
                && {1'b0, w_rch} < (XW+1)'(CHANNELS)) begin
                n_out.channel_value = r_chan[w_rch[CW-1:0]];
            end
            if (r_job.crc_bad) n_out.frame_event = exbus_pkg::EV_CRC;
            if (r_job.crc_ok) begin
                n_out.request_id = r_req;
                if (r_id == exbus_pkg::ID_CHAN) n_out.frame_event = exbus_pkg::EV_CHAN;
                else if (r_id == exbus_pkg::ID_TELE) n_out.frame_event = exbus_pkg::EV_TELE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_job <= i_job;
        r_hdr <= n_hdr;
        r_req <= n_req;
        r_id  <= n_id;
        r_n   <= n_n;
        r_ci  <= n_ci;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_st  <= exbus_pkg::BS_WAIT;
            r_bad <= '0;
            r_ok  <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_bad <= n_bad;
            r_ok  <= n_ok;
            r_ov  <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule
